### rtl/core/pmffs_pkg.sv
// ----------------------------------------------------------------------------
// Free frame stack memory package
// Shared widths, codes and interface types of the physical memory block.
// ----------------------------------------------------------------------------
package pmffs_pkg;

  localparam int unsigned MemBytesDef  = 1024;
  localparam int unsigned PageBytesDef = 256;
  localparam int unsigned StackDepth   = 4;
  localparam int unsigned AddrW        = 10;
  localparam int unsigned DataW        = 8;
  localparam int unsigned FrameW       = 2;
  localparam int unsigned CountW       = 3;

  typedef enum logic [1:0] {
    ActRead   = 2'd0,
    ActWrite  = 2'd1,
    ActTake   = 2'd2,
    ActReturn = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoFrame = 2'd1,
    StFull    = 2'd2
  } status_e;

  typedef struct packed {
    logic              pop;
    logic              push;
    logic [FrameW-1:0] frame;
  } stack_req_t;

  typedef struct packed {
    status_e           status;
    logic [FrameW-1:0] frame;
  } stack_rsp_t;

endpackage

### rtl/core/pmffs_free_stack.sv
// ----------------------------------------------------------------------------
// Free frame stack
// LIFO of free frame numbers with its fill count; answers a pop or push at once.
// ----------------------------------------------------------------------------
module pmffs_free_stack import pmffs_pkg::*; #(
  parameter int unsigned MEM_BYTES  = MemBytesDef,
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stack_req_t req_i,
  output stack_rsp_t rsp_o
);

  localparam int unsigned PageCnt = MEM_BYTES / PAGE_BYTES;
  localparam int unsigned Frames  = (PageCnt > StackDepth) ? StackDepth : PageCnt;

  logic [FrameW-1:0] stack_q [StackDepth];
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_dec;
  logic              can_pop;
  logic              can_push;

  assign count_dec = count_q - CountW'(1);
  assign can_pop   = (count_q != '0) && (count_q <= CountW'(StackDepth));
  assign can_push  = count_q < CountW'(StackDepth);

  always_comb begin
    rsp_o.status = StOk;
    rsp_o.frame  = '0;
    if (req_i.pop) begin
      if (can_pop) begin
        rsp_o.frame = stack_q[count_dec[FrameW-1:0]];
      end else begin
        rsp_o.status = StNoFrame;
      end
    end else if (req_i.push && !can_push) begin
      rsp_o.status = StFull;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(Frames);
      for (int i = 0; i < StackDepth; i++) begin
        stack_q[i] <= (i < Frames) ? FrameW'(Frames - 1 - i) : '0;
      end
    end else if (req_i.pop && can_pop) begin
      count_q <= count_dec;
    end else if (req_i.push && can_push) begin
      stack_q[count_q[FrameW-1:0]] <= req_i.frame;
      count_q                      <= count_q + CountW'(1);
    end
  end

endmodule

### rtl/core/pmffs_mem.sv
// ----------------------------------------------------------------------------
// Byte memory
// Single-port byte store with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pmffs_mem import pmffs_pkg::*; #(
  parameter int unsigned DEPTH = MemBytesDef,
  parameter int unsigned IDX_W = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o,
  output logic             clearing_o
);

  logic [DataW-1:0] mem_q [DEPTH];
  logic [DataW-1:0] rdata_q;
  logic [IDX_W-1:0] clr_idx_q;
  logic             clearing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      clr_idx_q <= clr_idx_q + IDX_W'(1);
      if (clr_idx_q == IDX_W'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[idx_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[idx_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

### rtl/core/phys_memory_free_frame_stack_top.sv
// ----------------------------------------------------------------------------
// Physical memory with free frame stack
// Byte memory with read and write, a cursor for sequential mode, and a
// LIFO of free page frames that can be taken and returned.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer when            Signals
// command   in         start_i && !busy_o      action_i addr_i data_i frame_i
// result    out        done_o (one cycle)      read_data_o frame_out_o status_o
//                                              cursor_pos_o
// config    in         cfg_valid_i && ready    cfg_data_i
//
// One command is taken every cycle while busy_o is low; its result appears
// in the next cycle. After reset busy_o stays high while the memory is
// cleared byte by byte.
// Configuration transfers are taken at any time, cfg_ready_o is always high.
// The receiver cannot stall, so there is no back-pressure on results.
// ----------------------------------------------------------------------------
module phys_memory_free_frame_stack_top import pmffs_pkg::*; #(
  parameter int unsigned MEM_BYTES  = MemBytesDef,
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        action_i,
  input  logic [AddrW-1:0]  addr_i,
  input  logic [DataW-1:0]  data_i,
  input  logic [FrameW-1:0] frame_i,
  output logic              done_o,
  output logic [DataW-1:0]  read_data_o,
  output logic [FrameW-1:0] frame_out_o,
  output logic [1:0]        status_o,
  output logic [AddrW-1:0]  cursor_pos_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i
);

  localparam int unsigned AddrSpan = 1 << AddrW;
  localparam int unsigned MemDepth = (MEM_BYTES > AddrSpan) ? AddrSpan : MEM_BYTES;
  localparam int unsigned IdxW     = $clog2(MemDepth);
  localparam int unsigned CmpW     = 18;

  action_e           act;
  logic              accept;
  logic              in_range;
  logic              is_mem;
  logic              clearing;
  logic [DataW-1:0]  rdata;
  stack_req_t        stk_req;
  stack_rsp_t        stk_rsp;

  logic              done_q;
  logic              rd_sel_q;
  status_e           status_q;
  logic [FrameW-1:0] frame_q;
  logic [AddrW-1:0]  cursor_q,  cursor_d;
  logic              random_access_q;

  assign act      = action_e'(action_i);
  assign accept   = start_i && !clearing;
  assign in_range = CmpW'(addr_i) < CmpW'(MEM_BYTES);
  assign is_mem   = (act == ActRead) || (act == ActWrite);

  assign stk_req.pop   = accept && (act == ActTake);
  assign stk_req.push  = accept && (act == ActReturn);
  assign stk_req.frame = frame_i;

  always_comb begin
    cursor_d = cursor_q;
    if (is_mem && !random_access_q) begin
      cursor_d = in_range ? addr_i : '0;
    end
  end

  pmffs_mem #(
    .DEPTH (MemDepth),
    .IDX_W (IdxW)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept && in_range && (act == ActWrite)),
    .rd_en_i    (accept && in_range && (act == ActRead)),
    .idx_i      (addr_i[IdxW-1:0]),
    .wdata_i    (data_i),
    .rdata_o    (rdata),
    .clearing_o (clearing)
  );

  pmffs_free_stack #(
    .MEM_BYTES  (MEM_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stk_req),
    .rsp_o  (stk_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q          <= 1'b0;
      rd_sel_q        <= 1'b0;
      status_q        <= StOk;
      frame_q         <= '0;
      cursor_q        <= '0;
      random_access_q <= 1'b1;
    end else begin
      done_q <= accept;
      if (cfg_valid_i) begin
        random_access_q <= cfg_data_i;
      end
      if (accept) begin
        rd_sel_q <= in_range && (act == ActRead);
        status_q <= stk_rsp.status;
        frame_q  <= stk_rsp.frame;
        cursor_q <= cursor_d;
      end
    end
  end

  assign busy_o       = clearing;
  assign done_o       = done_q;
  assign read_data_o  = rd_sel_q ? rdata : '0;
  assign frame_out_o  = frame_q;
  assign status_o     = status_q;
  assign cursor_pos_o = cursor_q;
  assign cfg_ready_o  = 1'b1;

endmodule

### rtl/core/pmffs_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Checks the command, result and busy behaviour seen on the top-level ports.
// ----------------------------------------------------------------------------
module pmffs_checker import pmffs_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic [DataW-1:0]  read_data_o,
  input logic [FrameW-1:0] frame_out_o,
  input logic [1:0]        status_o
);

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> done_o)
    else $error("A command transfer was not followed by a result.");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start_i || busy_o) |=> !done_o)
    else $error("A result appeared without a command transfer.");

  a_busy_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("Busy rose again after the clearing sweep.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= StFull))
    else $error("Result carries an undefined status code.");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != StOk) |-> (frame_out_o == '0) && (read_data_o == '0))
    else $error("A failed frame request returned data.");

endmodule

bind phys_memory_free_frame_stack_top pmffs_checker u_pmffs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .read_data_o (read_data_o),
  .frame_out_o (frame_out_o),
  .status_o    (status_o)
);
